// ===== hw/rtl/mmrm_pkg.sv =====
package mmrm_pkg;

  localparam int BYTE_W      = 8;
  localparam int POS_W       = 4;
  localparam int LEN_W       = 5;
  localparam int SLOT_FLD_W  = 2;
  localparam int MASK_W      = 4;
  localparam int CMD_W       = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int RESULT_W    = 1 + SLOT_FLD_W + MASK_W + MASK_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_RX_BYTE    = 2'd0,
    CMD_STAGE_BYTE = 2'd1,
    CMD_REGISTER   = 2'd2,
    CMD_REMOVE     = 2'd3
  } cmd_t;

  // per-slot control for one accepted beat
  typedef struct packed {
    logic              rx;
    logic              load;
    logic              remove;
    logic [BYTE_W-1:0] rx_byte;
    logic [LEN_W-1:0]  load_len;
  } slot_ctl_t;

  // first member sits in the high bits, so status ends up at bit 0
  typedef struct packed {
    logic [MASK_W-1:0]     matched_mask;
    logic [MASK_W-1:0]     armed_mask;
    logic [SLOT_FLD_W-1:0] allocated_slot;
    logic                  status;
  } result_t;

endpackage

// ===== hw/rtl/multi_marker_response_matcher.sv =====
// channel | dir | ports                         | beat
// in      | in  | in_tvalid/in_tready/in_tdata  | one command, kind in in_tuser
// out     | out | out_tvalid/out_tready/out_tdata | one result per command
//
// a beat is taken each cycle while in_tready is high; its result is queued
// all slot state updates at the edge that takes the beat, so the next beat
// sees it with no gap; the cost is the per-slot byte compare and the
// first-free-slot pick
// a two-entry result queue lets input keep flowing while a result waits;
// in_tready drops only when both entries are full
// synchronous active-low reset disarms every slot; no clearing pass is needed
module multi_marker_response_matcher #(
  parameter int MARKER_COUNT   = 4,
  parameter int MARKER_MAX_LEN = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [7:0] byte_value, [11:8] position, [16:12] marker_length, [18:17] slot
  input  logic [mmrm_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] cmd
  input  logic [mmrm_pkg::CMD_W-1:0]           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] status, [2:1] allocated_slot, [6:3] armed_mask, [10:7] matched_mask
  output logic [mmrm_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int SLOT_W = (MARKER_COUNT > 1) ? $clog2(MARKER_COUNT) : 1;

  // command fields
  mmrm_pkg::cmd_t                  cmd;
  logic [mmrm_pkg::BYTE_W-1:0]     byte_value;
  logic [mmrm_pkg::POS_W-1:0]      position;
  logic [mmrm_pkg::LEN_W-1:0]      marker_length;
  logic [mmrm_pkg::SLOT_FLD_W-1:0] slot;
  logic                            accept;

  assign accept        = in_tvalid && in_tready;
  assign cmd           = mmrm_pkg::cmd_t'(in_tuser);
  assign byte_value    = in_tdata[7:0];
  assign position      = in_tdata[11:8];
  assign marker_length = in_tdata[16:12];
  assign slot          = in_tdata[18:17];

  // staging buffer for the marker being built
  logic [MARKER_MAX_LEN-1:0][mmrm_pkg::BYTE_W-1:0] stage_bytes;

  mmrm_stage #(
    .MAX_LEN (MARKER_MAX_LEN)
  ) u_stage (
    .clk     (clk),
    .wr_en   (accept && (cmd == mmrm_pkg::CMD_STAGE_BYTE)),
    .wr_pos  (position),
    .wr_byte (byte_value),
    .bytes   (stage_bytes)
  );

  // registration: first slot not armed, length 1..max
  logic [MARKER_COUNT-1:0] armed;
  logic [MARKER_COUNT-1:0] armed_nxt;
  logic [MARKER_COUNT-1:0] hit;
  logic                    free_found;
  logic [SLOT_W-1:0]       free_idx;
  logic                    len_ok;
  logic                    reg_ok;
  logic                    slot_ok;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = MARKER_COUNT - 1; s >= 0; s--) begin
      if (!armed[s]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(s);
      end
    end
  end

  assign len_ok  = (marker_length != '0) &&
                   (8'(marker_length) <= 8'(MARKER_MAX_LEN));
  assign reg_ok  = (cmd == mmrm_pkg::CMD_REGISTER) && len_ok && free_found;
  assign slot_ok = 8'(slot) < 8'(MARKER_COUNT);

  // one matcher per slot
  for (genvar g = 0; g < MARKER_COUNT; g++) begin : g_slot
    mmrm_pkg::slot_ctl_t ctl;

    always_comb begin
      ctl.rx       = accept && (cmd == mmrm_pkg::CMD_RX_BYTE);
      ctl.load     = accept && reg_ok && (free_idx == SLOT_W'(g));
      ctl.remove   = accept && (cmd == mmrm_pkg::CMD_REMOVE) && slot_ok &&
                     (8'(slot) == 8'(g));
      ctl.rx_byte  = byte_value;
      ctl.load_len = marker_length;
    end

    mmrm_slot #(
      .MAX_LEN (MARKER_MAX_LEN)
    ) u_slot (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .stage_bytes (stage_bytes),
      .armed       (armed[g]),
      .armed_nxt   (armed_nxt[g]),
      .hit         (hit[g])
    );
  end

  // result assembly, only slots 0..3 are visible
  mmrm_pkg::result_t result;

  always_comb begin
    result.status         = (cmd == mmrm_pkg::CMD_REGISTER) && !reg_ok;
    result.allocated_slot = reg_ok ? mmrm_pkg::SLOT_FLD_W'(free_idx) : '0;
    result.armed_mask     = '0;
    result.matched_mask   = '0;
    for (int s = 0; s < mmrm_pkg::MASK_W; s++) begin
      if (s < MARKER_COUNT) begin
        result.armed_mask[s]   = armed_nxt[s];
        result.matched_mask[s] = hit[s];
      end
    end
  end

  logic [mmrm_pkg::RESULT_W-1:0] out_word;

  mmrm_outq #(
    .W (mmrm_pkg::RESULT_W)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .din       (result),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .dout      (out_word)
  );

  assign out_tdata = {{(mmrm_pkg::OUT_TDATA_W - mmrm_pkg::RESULT_W){1'b0}}, out_word};

endmodule

// ===== hw/rtl/mmrm_stage.sv =====
module mmrm_stage #(
  parameter int MAX_LEN = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [mmrm_pkg::POS_W-1:0]              wr_pos,
  input  logic [mmrm_pkg::BYTE_W-1:0]             wr_byte,
  output logic [MAX_LEN-1:0][mmrm_pkg::BYTE_W-1:0] bytes
);

  localparam int IDX_W = $clog2(MAX_LEN);

  logic [MAX_LEN-1:0][mmrm_pkg::BYTE_W-1:0] store_r;
  logic                                     pos_ok;

  // positions past the buffer are dropped
  assign pos_ok = 8'(wr_pos) < 8'(MAX_LEN);

  always_ff @(posedge clk) begin
    if (wr_en && pos_ok) begin
      store_r[IDX_W'(wr_pos)] <= wr_byte;
    end
  end

  assign bytes = store_r;

endmodule

// ===== hw/rtl/mmrm_slot.sv =====
module mmrm_slot #(
  parameter int MAX_LEN = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  mmrm_pkg::slot_ctl_t                      ctl,
  input  logic [MAX_LEN-1:0][mmrm_pkg::BYTE_W-1:0] stage_bytes,
  output logic                                     armed,
  output logic                                     armed_nxt,
  output logic                                     hit
);

  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int PROG_W = $clog2(MAX_LEN + 1);

  logic [MAX_LEN-1:0][mmrm_pkg::BYTE_W-1:0] bytes_r;
  logic [PROG_W-1:0] len_r, len_nxt;
  logic [PROG_W-1:0] prog_r, prog_nxt;
  logic              armed_r;
  logic [PROG_W-1:0] prog_inc;
  logic              in_range;
  logic              match;
  logic [mmrm_pkg::BYTE_W-1:0] cur_byte;

  always_comb begin
    in_range  = prog_r < PROG_W'(MAX_LEN);
    cur_byte  = bytes_r[prog_r[IDX_W-1:0]];
    prog_inc  = prog_r + 1'b1;
    match     = armed_r && in_range && (cur_byte == ctl.rx_byte);
    prog_nxt  = prog_r;
    len_nxt   = len_r;
    armed_nxt = armed_r;
    hit       = 1'b0;
    if (ctl.rx) begin
      if (match) begin
        prog_nxt = prog_inc;
        if (prog_inc >= len_r) begin
          armed_nxt = 1'b0;
          hit       = 1'b1;
        end
      end else begin
        // mismatch drops progress, byte is not rechecked
        prog_nxt = '0;
      end
    end
    if (ctl.load) begin
      len_nxt   = PROG_W'(ctl.load_len);
      prog_nxt  = '0;
      armed_nxt = 1'b1;
    end
    if (ctl.remove) begin
      armed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      prog_r  <= '0;
      armed_r <= 1'b0;
    end else begin
      len_r   <= len_nxt;
      prog_r  <= prog_nxt;
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bytes_r <= stage_bytes;
    end
  end

  assign armed = armed_r;

endmodule

// ===== hw/rtl/mmrm_outq.sv =====
module mmrm_outq #(
  parameter int W = 11
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         can_push,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] dout
);

  logic [1:0]   count_r, count_nxt;
  logic [W-1:0] e0_r, e0_nxt;
  logic [W-1:0] e1_r, e1_nxt;
  logic         pop;

  always_comb begin
    pop       = (count_r != 2'd0) && out_ready;
    count_nxt = count_r;
    e0_nxt    = e0_r;
    e1_nxt    = e1_r;
    if (pop && push) begin
      if (count_r == 2'd2) begin
        e0_nxt = e1_r;
        e1_nxt = din;
      end else begin
        e0_nxt = din;
      end
    end else if (pop) begin
      e0_nxt    = e1_r;
      count_nxt = count_r - 2'd1;
    end else if (push) begin
      if (count_r == 2'd0) begin
        e0_nxt = din;
      end else begin
        e1_nxt = din;
      end
      count_nxt = count_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign can_push  = count_r != 2'd2;
  assign out_valid = count_r != 2'd0;
  assign dout      = e0_r;

endmodule

// ===== bench/multi_marker_response_matcher_tb.sv =====
module multi_marker_response_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 4;
  localparam int MAX_LEN      = 16;
  localparam int RANDOM_BEATS = 1200;
  localparam int DRAIN_EVERY  = 300;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  // [7:0] byte_value, [11:8] position, [16:12] marker_length, [18:17] slot
  logic [mmrm_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;
  // [1:0] cmd
  logic [mmrm_pkg::CMD_W-1:0]       in_tuser  = mmrm_pkg::CMD_RX_BYTE;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // [0] status, [2:1] allocated_slot, [6:3] armed_mask, [10:7] matched_mask
  logic [mmrm_pkg::OUT_TDATA_W-1:0] out_tdata;

  multi_marker_response_matcher #(
    .MARKER_COUNT  (SLOTS),
    .MARKER_MAX_LEN(MAX_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the matcher: marker slots, their progress and the staging buffer
  logic [mmrm_pkg::BYTE_W-1:0] slot_text     [SLOTS][MAX_LEN];
  logic [mmrm_pkg::LEN_W-1:0]  slot_len      [SLOTS];
  logic [mmrm_pkg::LEN_W-1:0]  slot_progress [SLOTS];
  logic [SLOTS-1:0]            slot_armed;
  logic [mmrm_pkg::BYTE_W-1:0] staged_text   [MAX_LEN];

  // results owed by the block, oldest first
  mmrm_pkg::result_t expected_results[$];

  // staging positions written since reset, tracked on the sending side so a
  // registration never copies a byte that was never staged
  logic [MAX_LEN-1:0] staged_done = '0;

  // directed rows
  typedef struct {
    mmrm_pkg::cmd_t                  cmd;
    logic [mmrm_pkg::BYTE_W-1:0]     value;
    logic [mmrm_pkg::POS_W-1:0]      pos;
    logic [mmrm_pkg::LEN_W-1:0]      len;
    logic [mmrm_pkg::SLOT_FLD_W-1:0] slot;
    bit                              typed;
    mmrm_pkg::result_t               want;
  } step_row_t;

  step_row_t dir_rows[$];

  int err_count   = 0;
  int beats_in    = 0;
  int checked     = 0;
  int reg_ok      = 0;
  int reg_full    = 0;
  int reg_reject  = 0;
  int completions = 0;
  int burst_left  = 0;

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= 30)
      $display("%0t: mismatch on %s, got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // one command through the shadow matcher
  function automatic mmrm_pkg::result_t match_step(mmrm_pkg::cmd_t c,
                                                   logic [mmrm_pkg::BYTE_W-1:0] v,
                                                   logic [mmrm_pkg::POS_W-1:0] p,
                                                   logic [mmrm_pkg::LEN_W-1:0] l,
                                                   logic [mmrm_pkg::SLOT_FLD_W-1:0] s);
    mmrm_pkg::result_t r;
    int                i;
    int                k;
    bit                placed;
    r      = '0;
    placed = 1'b0;
    case (c)
      mmrm_pkg::CMD_RX_BYTE: begin
        for (i = 0; i < SLOTS; i++) begin
          // a mismatch drops progress to zero, the byte is not retried
          // against the first marker byte; idle slots also clear
          if (slot_armed[i] && slot_progress[i] < MAX_LEN &&
              slot_text[i][slot_progress[i][mmrm_pkg::POS_W-1:0]] == v) begin
            slot_progress[i] = slot_progress[i] + 1'b1;
            if (slot_progress[i] >= slot_len[i]) begin
              slot_armed[i]     = 1'b0;
              r.matched_mask[i] = 1'b1;
            end
          end else begin
            slot_progress[i] = '0;
          end
        end
      end
      mmrm_pkg::CMD_STAGE_BYTE: begin
        if (int'(p) < MAX_LEN) staged_text[p] = v;
      end
      mmrm_pkg::CMD_REGISTER: begin
        r.status = 1'b1;
        if (l >= 1 && l <= MAX_LEN) begin
          for (i = 0; i < SLOTS && !placed; i++) begin
            if (!slot_armed[i]) begin
              for (k = 0; k < int'(l); k++) slot_text[i][k] = staged_text[k];
              slot_len[i]      = l;
              slot_progress[i] = '0;
              slot_armed[i]    = 1'b1;
              r.status         = 1'b0;
              r.allocated_slot = mmrm_pkg::SLOT_FLD_W'(i);
              placed           = 1'b1;
            end
          end
        end
      end
      mmrm_pkg::CMD_REMOVE: begin
        if (int'(s) < SLOTS) slot_armed[s] = 1'b0;
      end
      default: ;
    endcase
    r.armed_mask = slot_armed[mmrm_pkg::MASK_W-1:0];
    return r;
  endfunction

  function automatic mmrm_pkg::result_t res(bit st, int alloc, logic [3:0] armed,
                                            logic [3:0] hit);
    mmrm_pkg::result_t r;
    r.status         = st;
    r.allocated_slot = mmrm_pkg::SLOT_FLD_W'(alloc);
    r.armed_mask     = armed;
    r.matched_mask   = hit;
    return r;
  endfunction

  task automatic add_row(mmrm_pkg::cmd_t c, int v, int p, int l, int s, bit typed,
                         mmrm_pkg::result_t want);
    step_row_t row;
    row.cmd   = c;
    row.value = mmrm_pkg::BYTE_W'(v);
    row.pos   = mmrm_pkg::POS_W'(p);
    row.len   = mmrm_pkg::LEN_W'(l);
    row.slot  = mmrm_pkg::SLOT_FLD_W'(s);
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // longest run of staging positions written from position 0
  function automatic int staged_prefix();
    int n;
    n = 0;
    while (n < MAX_LEN && staged_done[n]) n++;
    return n;
  endfunction

  // offer one beat after the gap the burst pattern asks for, wait for the
  // handshake and queue what the block owes for it
  task automatic send_beat(mmrm_pkg::cmd_t c, logic [mmrm_pkg::BYTE_W-1:0] v,
                           logic [mmrm_pkg::POS_W-1:0] p,
                           logic [mmrm_pkg::LEN_W-1:0] l,
                           logic [mmrm_pkg::SLOT_FLD_W-1:0] s,
                           bit typed = 1'b0, mmrm_pkg::result_t want = '0);
    int                gap;
    mmrm_pkg::result_t predicted;
    if (burst_left == 0) begin
      gap        = $urandom_range(8, 1);
      // now and then a long burst with no idle cycles at all
      burst_left = ($urandom_range(9, 0) == 0) ? 80 : $urandom_range(24, 1);
    end else begin
      gap = 0;
      burst_left--;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(mmrm_pkg::IN_TDATA_W - 19){1'b0}}, s, l, p, v};
    in_tuser  <= c;
    do @(posedge clk); while (!in_tready);
    // beat taken at this edge
    beats_in++;
    if (c == mmrm_pkg::CMD_STAGE_BYTE) staged_done[p] = 1'b1;
    predicted = match_step(c, v, p, l, s);
    if (c == mmrm_pkg::CMD_REGISTER) begin
      if (predicted.status) reg_reject++;
      else begin
        reg_ok++;
        if (l == MAX_LEN) reg_full++;
      end
    end
    completions += $countones(predicted.matched_mask);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // sender holds back until the block has delivered everything it owes
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // result side: compare every accepted beat with the oldest expectation
  always @(posedge clk) begin : result_check
    mmrm_pkg::result_t got;
    mmrm_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = mmrm_pkg::result_t'(out_tdata[mmrm_pkg::RESULT_W-1:0]);
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", int'(out_tdata), 0);
      end else begin
        want = expected_results.pop_front();
        checked++;
        if (got.status != want.status)
          report_mismatch("status", got.status, want.status);
        if (got.allocated_slot != want.allocated_slot)
          report_mismatch("allocated_slot", got.allocated_slot, want.allocated_slot);
        if (got.armed_mask != want.armed_mask)
          report_mismatch("armed_mask", got.armed_mask, want.armed_mask);
        if (got.matched_mask != want.matched_mask)
          report_mismatch("matched_mask", got.matched_mask, want.matched_mask);
      end
    end
  end

  // receiver: stall pattern is redrawn at random from four modes, with two long
  // hold-offs so the result queue fills and in_tready drops
  initial begin : result_side
    int cyc;
    int hold;
    int mode;
    cyc  = 0;
    hold = 0;
    mode = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      cyc++;
      if (cyc == 300 || cyc == 2500) hold = 64;
      if (cyc % 50 == 0) mode = $urandom_range(3, 0);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= (cyc % 3 == 0);
          2: out_tready <= 1'($urandom_range(1, 0));
          default: out_tready <= (cyc % 8 < 5);
        endcase
      end
      @(posedge clk);
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("multi_marker_response_matcher_tb failed");
    $finish;
  end

  initial begin : stimulus
    logic [mmrm_pkg::BYTE_W-1:0] recent_bytes [4][MAX_LEN];
    int                          recent_len   [4];
    int                          recent_cnt;
    int                          recent_wr;
    int                          newest;
    int                          next_drain;
    int                          mlen;
    int                          streams;
    int                          pick;
    int                          j;
    int                          k;
    int                          n;
    int                          l;
    bit                          narrow;
    mmrm_pkg::cmd_t              c;
    recent_cnt = 0;
    recent_wr  = 0;
    next_drain = DRAIN_EVERY;

    // shadow state after reset: slots idle, stores unknown but held at zero
    slot_armed = '0;
    for (j = 0; j < SLOTS; j++) begin
      slot_len[j]      = '0;
      slot_progress[j] = '0;
      for (k = 0; k < MAX_LEN; k++) slot_text[j][k] = '0;
    end
    for (k = 0; k < MAX_LEN; k++) staged_text[k] = '0;

    // receive byte right after reset: nothing armed, all zero
    add_row(mmrm_pkg::CMD_RX_BYTE,    8'h00, 0, 0,  0, 1, res(0, 0, 4'b0000, 4'b0000));
    // bad lengths: zero, the field maximum, one past the buffer
    add_row(mmrm_pkg::CMD_REGISTER,   0,     0, 0,  0, 1, res(1, 0, 4'b0000, 4'b0000));
    add_row(mmrm_pkg::CMD_REGISTER,   0,     0, 31, 0, 1, res(1, 0, 4'b0000, 4'b0000));
    add_row(mmrm_pkg::CMD_REGISTER,   0,     0, 17, 0, 1, res(1, 0, 4'b0000, 4'b0000));
    // removing an idle slot is harmless
    add_row(mmrm_pkg::CMD_REMOVE,     0,     0, 0,  3, 1, res(0, 0, 4'b0000, 4'b0000));
    // last staging position
    add_row(mmrm_pkg::CMD_STAGE_BYTE, 8'h00, 15, 0, 0, 0, '0);
    // "AB" into slot 0, "A" into slot 1
    add_row(mmrm_pkg::CMD_STAGE_BYTE, 8'h41, 0, 0,  0, 0, '0);
    add_row(mmrm_pkg::CMD_STAGE_BYTE, 8'h42, 1, 0,  0, 0, '0);
    add_row(mmrm_pkg::CMD_REGISTER,   0,     0, 2,  0, 1, res(0, 0, 4'b0001, 4'b0000));
    add_row(mmrm_pkg::CMD_REGISTER,   0,     0, 1,  0, 1, res(0, 1, 4'b0011, 4'b0000));
    // FF 00 into slot 2, FF into slot 3
    add_row(mmrm_pkg::CMD_STAGE_BYTE, 8'hFF, 0, 0,  0, 0, '0);
    add_row(mmrm_pkg::CMD_STAGE_BYTE, 8'h00, 1, 0,  0, 0, '0);
    add_row(mmrm_pkg::CMD_REGISTER,   0,     0, 2,  0, 1, res(0, 2, 4'b0111, 4'b0000));
    add_row(mmrm_pkg::CMD_REGISTER,   0,     0, 1,  0, 1, res(0, 3, 4'b1111, 4'b0000));
    // every slot armed: no free slot
    add_row(mmrm_pkg::CMD_REGISTER,   0,     0, 1,  0, 1, res(1, 0, 4'b1111, 4'b0000));
    // "A" completes slot 1; second "A" breaks slot 0 and is not retried,
    // so the following "B" completes nothing
    add_row(mmrm_pkg::CMD_RX_BYTE,    8'h41, 0, 0,  0, 0, '0);
    add_row(mmrm_pkg::CMD_RX_BYTE,    8'h41, 0, 0,  0, 0, '0);
    add_row(mmrm_pkg::CMD_RX_BYTE,    8'h42, 0, 0,  0, 0, '0);
    // FF completes slot 3 and starts slot 2, then "AB" completes slot 0
    add_row(mmrm_pkg::CMD_RX_BYTE,    8'hFF, 0, 0,  0, 0, '0);
    add_row(mmrm_pkg::CMD_RX_BYTE,    8'h41, 0, 0,  0, 0, '0);
    add_row(mmrm_pkg::CMD_RX_BYTE,    8'h42, 0, 0,  0, 0, '0);
    // remove an armed slot, then an idle one, then receive with nothing armed
    add_row(mmrm_pkg::CMD_REMOVE,     0,     0, 0,  2, 0, '0);
    add_row(mmrm_pkg::CMD_REMOVE,     0,     0, 0,  0, 0, '0);
    add_row(mmrm_pkg::CMD_RX_BYTE,    8'hFF, 0, 0,  0, 0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].pos, dir_rows[i].len,
                dir_rows[i].slot, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    while (beats_in < RANDOM_BEATS + dir_rows.size()) begin
      if (beats_in >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
      end
      if ($urandom_range(99, 0) < 65) begin
        // well-formed: stage a whole marker, register it, then feed it back
        n = $urandom_range(9, 0);
        mlen   = (n < 2) ? MAX_LEN : (n == 2) ? 1 : $urandom_range(MAX_LEN, 1);
        narrow = 1'($urandom_range(1, 0));
        for (k = 0; k < mlen; k++) begin
          recent_bytes[recent_wr][k] =
            narrow ? mmrm_pkg::BYTE_W'(8'h41 + $urandom_range(3, 0))
                   : mmrm_pkg::BYTE_W'($urandom_range(255, 0));
          send_beat(mmrm_pkg::CMD_STAGE_BYTE, recent_bytes[recent_wr][k],
                    mmrm_pkg::POS_W'(k), mmrm_pkg::LEN_W'($urandom),
                    mmrm_pkg::SLOT_FLD_W'($urandom));
        end
        if ($urandom_range(4, 0) == 0)
          send_beat(mmrm_pkg::CMD_REMOVE, mmrm_pkg::BYTE_W'($urandom),
                    mmrm_pkg::POS_W'($urandom), mmrm_pkg::LEN_W'($urandom),
                    mmrm_pkg::SLOT_FLD_W'($urandom_range(3, 0)));
        send_beat(mmrm_pkg::CMD_REGISTER, mmrm_pkg::BYTE_W'($urandom),
                  mmrm_pkg::POS_W'($urandom), mmrm_pkg::LEN_W'(mlen),
                  mmrm_pkg::SLOT_FLD_W'($urandom));
        recent_len[recent_wr] = mlen;
        newest     = recent_wr;
        recent_wr  = (recent_wr + 1) % 4;
        if (recent_cnt < 4) recent_cnt++;
        streams = $urandom_range(3, 1);
        for (j = 0; j < streams; j++) begin
          pick = (j == 0) ? newest : $urandom_range(recent_cnt - 1, 0);
          for (k = 0; k < recent_len[pick]; k++) begin
            // stray byte now and then breaks a partial match
            if ($urandom_range(9, 0) == 0)
              send_beat(mmrm_pkg::CMD_RX_BYTE, mmrm_pkg::BYTE_W'($urandom),
                        mmrm_pkg::POS_W'($urandom), mmrm_pkg::LEN_W'($urandom),
                        mmrm_pkg::SLOT_FLD_W'($urandom));
            send_beat(mmrm_pkg::CMD_RX_BYTE, recent_bytes[pick][k],
                      mmrm_pkg::POS_W'($urandom), mmrm_pkg::LEN_W'($urandom),
                      mmrm_pkg::SLOT_FLD_W'($urandom));
          end
        end
      end else begin
        // noise: any command with random fields
        n = $urandom_range(4, 1);
        for (j = 0; j < n; j++) begin
          c = mmrm_pkg::cmd_t'($urandom_range(3, 0));
          l = $urandom_range(31, 0);
          // a valid length may only cover staging bytes already written
          if (c == mmrm_pkg::CMD_REGISTER && l >= 1 && l <= MAX_LEN &&
              l > staged_prefix())
            l = staged_prefix();
          send_beat(c, mmrm_pkg::BYTE_W'($urandom), mmrm_pkg::POS_W'($urandom),
                    mmrm_pkg::LEN_W'(l), mmrm_pkg::SLOT_FLD_W'($urandom));
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk);

    $display("%0d command beats sent, %0d results checked, %0d marker completions",
             beats_in, checked, completions);
    $display("%0d markers registered (%0d of full length), %0d registrations rejected",
             reg_ok, reg_full, reg_reject);
    if (err_count == 0) begin
      $display("multi_marker_response_matcher_tb passed");
    end else begin
      $display("multi_marker_response_matcher_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mmrm_pkg.sv
hw/rtl/mmrm_stage.sv
hw/rtl/mmrm_slot.sv
hw/rtl/mmrm_outq.sv
hw/rtl/multi_marker_response_matcher.sv
bench/multi_marker_response_matcher_tb.sv
